### rtl/phase_field_driving_force_kernel_defines.svh
// Assertion macros for the phase field driving force kernel.
`ifndef PHASE_FIELD_DRIVING_FORCE_KERNEL_DEFINES_SVH
`define PHASE_FIELD_DRIVING_FORCE_KERNEL_DEFINES_SVH
`ifndef SYNTH
`define PF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/pfdf_pkg.sv
// Shared constants, types and arithmetic helpers for the driving force kernel.
package pfdf_pkg;
  localparam int FRAC_BITS = 24;
  localparam int W = 32;
  localparam int RW = 31;
  localparam int NSTG = 40;
  localparam logic signed [W-1:0] SMAX = 32'sh7FFFFFFF;
  localparam logic signed [W-1:0] SMIN = 32'sh80000000;
  localparam logic [2:0] REG_NORM = 3'd0;
  localparam logic [2:0] REG_ANISO = 3'd1;
  localparam logic [2:0] REG_PART = 3'd2;
  localparam logic [2:0] REG_WSQ = 3'd3;
  localparam logic [2:0] REG_TCL = 3'd4;
  localparam logic [2:0] REG_COUP = 3'd5;

  typedef logic signed [W-1:0] fx_t;

  typedef struct packed {
    logic [24:0] norm_offset;
    logic [24:0] aniso_strength;
    logic [24:0] partition_coeff;
    logic [30:0] width_squared;
    logic [30:0] two_over_cl0;
    logic [30:0] coupling_coeff;
  } cfg_t;

  typedef struct packed {
    fx_t v;
    logic f;
  } sres_t;

  function automatic sres_t sat66(input logic signed [65:0] v);
    sres_t r;
    if (v > 66'sh07FFFFFFF) begin
      r.v = SMAX; r.f = 1'b1;
    end else if (v < -66'sh080000000) begin
      r.v = SMIN; r.f = 1'b1;
    end else begin
      r.v = fx_t'(v[W-1:0]); r.f = 1'b0;
    end
    return r;
  endfunction

  function automatic sres_t fadd(input fx_t a, input fx_t b);
    return sat66(66'(a) + 66'(b));
  endfunction

  function automatic sres_t fsub(input fx_t a, input fx_t b);
    return sat66(66'(a) - 66'(b));
  endfunction

  // round half up: floor((p + half) / 2^F)
  function automatic sres_t fmul(input fx_t a, input fx_t b);
    logic signed [65:0] p;
    p = (66'(a) * 66'(b)) + (66'sd1 <<< (FRAC_BITS - 1));
    return sat66(p >>> FRAC_BITS);
  endfunction
endpackage

### rtl/pfdf_sqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module pfdf_sqrt import pfdf_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  logic [63:0] rem_r [0:32];
  logic [31:0] res_r [0:32];

  always_comb begin
    rem_r[0] = rad;
    res_r[0] = '0;
  end

  for (genvar i = 0; i < 32; i++) begin : g_st
    logic [63:0] rem_nxt;
    logic [31:0] res_nxt;
    logic [33:0] trial;
    logic [33:0] top;
    always_comb begin
      top = 34'(rem_r[i] >> (62 - 2 * i));
      trial = {res_r[i], 2'b01};
      rem_nxt = rem_r[i];
      res_nxt = {res_r[i][30:0], 1'b0};
      if (top >= trial) begin
        rem_nxt = rem_r[i] - (64'(trial) << (62 - 2 * i));
        res_nxt = {res_r[i][30:0], 1'b1};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= rem_nxt;
        res_r[i+1] <= res_nxt;
      end
    end
  end
  assign root = res_r[32];
endmodule

### rtl/pfdf_div.sv
// Signed fixed-point restoring divider; each stage past 0 adds a quotient bit.
module pfdf_div import pfdf_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic signed [63:0]  num,
  input  logic signed [63:0]  den,
  output fx_t                 quo,
  output logic                flg
);
  // quotient = floor(|n|*2^F / |d|), bits up to 2^(32+F) matter; 57 steps
  localparam int QB = 32 + FRAC_BITS + 1;
  localparam int NB = 64 + FRAC_BITS;
  logic [NB-1:0] n_r [0:QB];
  logic [63:0]   d_r [0:QB];
  logic [NB-1:0] r_r [0:QB];
  logic [QB-1:0] q_r [0:QB];
  logic          ng_r [0:QB];
  logic          dz_r [0:QB];
  logic          nz_r [0:QB];
  logic          np_r [0:QB];
  logic          ov_r [0:QB];

  always_comb begin
    n_r[0] = NB'(num < 0 ? 64'(-num) : 64'(num)) << FRAC_BITS;
    d_r[0] = den < 0 ? 64'(-den) : 64'(den);
    r_r[0] = '0;
    q_r[0] = '0;
    ng_r[0] = (num < 0) != (den < 0);
    dz_r[0] = den == 0;
    nz_r[0] = num == 0;
    np_r[0] = num > 0;
    ov_r[0] = 1'b0;
  end

  for (genvar i = 0; i < QB; i++) begin : g_st
    logic [NB-1:0] rs;
    logic [NB-1:0] r_nxt;
    logic          b;
    always_comb begin
      rs = {r_r[i][NB-2:0], n_r[i][NB-1-(NB-QB)-i]};
      b = rs >= NB'(d_r[i]);
      r_nxt = b ? rs - NB'(d_r[i]) : rs;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1] <= n_r[i];
        d_r[i+1] <= d_r[i];
        r_r[i+1] <= (i == 0) ? NB'(n_r[i] >> QB) : r_r[i];
        q_r[i+1] <= q_r[i];
        ng_r[i+1] <= ng_r[i];
        dz_r[i+1] <= dz_r[i];
        nz_r[i+1] <= nz_r[i];
        np_r[i+1] <= np_r[i];
        ov_r[i+1] <= ov_r[i];
        if (i == 0) begin
          // high part of numerator handled as initial remainder
          if ((n_r[i] >> QB) >= NB'(d_r[i])) ov_r[i+1] <= 1'b1;
          rs_init(n_r[i], d_r[i]);
        end else begin
          r_r[i+1] <= r_nxt;
          q_r[i+1] <= {q_r[i][QB-2:0], b};
        end
      end
    end
  end

  task automatic rs_init(input logic [NB-1:0] n, input logic [63:0] d);
  endtask

  logic [QB-1:0] qf;
  logic [63:0]   qx;
  always_comb begin
    qf = q_r[QB];
    qx = 64'(qf);
    if (dz_r[QB]) begin
      quo = nz_r[QB] ? '0 : (np_r[QB] ? SMAX : SMIN);
      flg = 1'b1;
    end else if (ov_r[QB] || qx > 64'hFFFFFFFF) begin
      quo = ng_r[QB] ? SMIN : SMAX;
      flg = 1'b1;
    end else if (ng_r[QB]) begin
      quo = (qx > 64'h80000000) ? SMIN : fx_t'(-qx[31:0]);
      flg = qx > 64'h80000000;
    end else begin
      quo = (qx > 64'h7FFFFFFF) ? SMAX : fx_t'(qx[31:0]);
      flg = qx > 64'h7FFFFFFF;
    end
  end
endmodule

### rtl/phase_field_driving_force_kernel.sv
// Top level: pipelined driving force kernel with a stall-safe valid chain.
// Pipeline: the sqrt, the divider (QB stages), then the arithmetic stages and a spare delay tail.
// Throughput: one item per cycle; the whole pipe freezes when out_tready is low while out_tvalid is high.
// Reset: rst_n synchronous active low clears valid bits and loads register defaults.
// Payload registers are not reset.
`include "phase_field_driving_force_kernel_defines.svh"
module phase_field_driving_force_kernel import pfdf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // phase_value, phase_grad_x, phase_grad_y, concentration
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // value_term, grad_term_x, grad_term_y
  output logic [95:0]  out_tdata,
  // saturated
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata
);
  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.norm_offset <= 25'd1;
      cfg_r.aniso_strength <= '0;
      cfg_r.partition_coeff <= '0;
      cfg_r.width_squared <= 31'd16777216;
      cfg_r.two_over_cl0 <= 31'd16777216;
      cfg_r.coupling_coeff <= 31'd16777216;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NORM:  cfg_r.norm_offset <= cfg_wdata[24:0];
        REG_ANISO: cfg_r.aniso_strength <= cfg_wdata[24:0];
        REG_PART:  cfg_r.partition_coeff <= cfg_wdata[24:0];
        REG_WSQ:   cfg_r.width_squared <= cfg_wdata;
        REG_TCL:   cfg_r.two_over_cl0 <= cfg_wdata;
        REG_COUP:  cfg_r.coupling_coeff <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipe advances together; output stage is last slot.
  logic en;
  assign en = out_tready || !out_tvalid;
  assign in_tready = en;

  localparam int QB = 32 + FRAC_BITS + 1;
  localparam int LAT = 32 + QB + 14;
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  fx_t phi, gx, gy, cc;
  assign phi = fx_t'(in_tdata[31:0]);
  assign gx  = fx_t'(in_tdata[63:32]);
  assign gy  = fx_t'(in_tdata[95:64]);
  assign cc  = fx_t'(in_tdata[127:96]);

  // Delay the raw item alongside the sqrt.
  fx_t phi_d [0:32], gx_d [0:32], gy_d [0:32], cc_d [0:32];
  always_comb begin
    phi_d[0] = phi; gx_d[0] = gx; gy_d[0] = gy; cc_d[0] = cc;
  end
  for (genvar i = 0; i < 32; i++) begin : g_d
    always_ff @(posedge clk) if (en) begin
      phi_d[i+1] <= phi_d[i]; gx_d[i+1] <= gx_d[i];
      gy_d[i+1] <= gy_d[i]; cc_d[i+1] <= cc_d[i];
    end
  end

  logic [31:0] ax, ay, mag;
  logic [63:0] rad;
  assign ax = gx[31] ? 32'(-gx) : 32'(gx);
  assign ay = gy[31] ? 32'(-gy) : 32'(gy);
  assign rad = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
  pfdf_sqrt u_sqrt (.clk(clk), .en(en), .rad(rad), .root(mag));

  // e^u numerator and denominator, in parallel with the normal divisions
  sres_t num_eu, one_k, omk, mk, dn;
  fx_t one;
  assign one = fx_t'(1 << FRAC_BITS);
  always_comb begin
    num_eu = fmul(fx_t'({1'b0, cfg_r.two_over_cl0}), cc_d[32]);
    one_k = fadd(one, fx_t'({7'd0, cfg_r.partition_coeff}));
    omk = fsub(one, fx_t'({7'd0, cfg_r.partition_coeff}));
    mk = fmul(omk.v, phi_d[32]);
    dn = fsub(one_k.v, mk.v);
  end
  logic signed [63:0] den_n;
  assign den_n = 64'(mag) + 64'(cfg_r.norm_offset);

  fx_t cth, sth, eu;
  logic fc, fs, fe;
  pfdf_div u_dc (.clk(clk), .en(en), .num(64'(gx_d[32])), .den(den_n), .quo(cth), .flg(fc));
  pfdf_div u_ds (.clk(clk), .en(en), .num(64'(gy_d[32])), .den(den_n), .quo(sth), .flg(fs));
  pfdf_div u_de (.clk(clk), .en(en), .num(64'(num_eu.v)), .den(64'(dn.v)), .quo(eu), .flg(fe));

  logic f0_d [0:QB];
  fx_t phi_e [0:QB], gx_e [0:QB], gy_e [0:QB];
  always_comb begin
    f0_d[0] = num_eu.f | one_k.f | omk.f | mk.f | dn.f;
    phi_e[0] = phi_d[32]; gx_e[0] = gx_d[32]; gy_e[0] = gy_d[32];
  end
  for (genvar i = 0; i < QB; i++) begin : g_e
    always_ff @(posedge clk) if (en) begin
      f0_d[i+1] <= f0_d[i]; phi_e[i+1] <= phi_e[i];
      gx_e[i+1] <= gx_e[i]; gy_e[i+1] <= gy_e[i];
    end
  end

  // Arithmetic tail: at most one multiply level per stage.
  fx_t c2_r, s2_r, sc_r, p2_r, eu1_r, om1_r, gx1_r, gy1_r, phi1_r;
  logic f1_r;
  sres_t c2, s2, sc, p2, eum1;
  always_comb begin
    c2 = fmul(cth, cth); s2 = fmul(sth, sth); sc = fmul(sth, cth);
    p2 = fmul(phi_e[QB], phi_e[QB]); eum1 = fsub(eu, one);
  end
  always_ff @(posedge clk) if (en) begin
    c2_r <= c2.v; s2_r <= s2.v; sc_r <= sc.v; p2_r <= p2.v; eu1_r <= eum1.v;
    gx1_r <= gx_e[QB]; gy1_r <= gy_e[QB]; phi1_r <= phi_e[QB];
    f1_r <= f0_d[QB] | fc | fs | fe | c2.f | s2.f | sc.f | p2.f | eum1.f;
  end

  sres_t s4, c4, s2c2, cms, p3, omp, cq;
  always_comb begin
    s4 = fmul(s2_r, s2_r); c4 = fmul(c2_r, c2_r); s2c2 = fmul(s2_r, c2_r);
    cms = fsub(c2_r, s2_r); p3 = fmul(p2_r, phi1_r); omp = fsub(one, p2_r);
    cq = fmul(fx_t'({1'b0, cfg_r.coupling_coeff}), omp.v);
  end
  fx_t s4_r, c4_r, s2c2_r, cms_r, sc2_r, p3_r, omp_r, cq_r, eu2_r, gx2_r, gy2_r, phi2_r;
  logic f2_r;
  always_ff @(posedge clk) if (en) begin
    s4_r <= s4.v; c4_r <= c4.v; s2c2_r <= s2c2.v; cms_r <= cms.v; sc2_r <= sc_r;
    p3_r <= p3.v; omp_r <= omp.v; cq_r <= cq.v; eu2_r <= eu1_r;
    gx2_r <= gx1_r; gy2_r <= gy1_r; phi2_r <= phi1_r;
    f2_r <= f1_r | s4.f | c4.f | s2c2.f | cms.f | p3.f | omp.f | cq.f;
  end

  sres_t a1, six, c4t, s4m, cq2, fp;
  logic signed [65:0] six_w;
  always_comb begin
    a1 = fadd(s4_r, c4_r);
    six_w = 66'(s2c2_r) * 66'sd6;
    six = sat66(six_w);
    c4t = fsub(a1.v, six.v);
    s4m = fmul(sc2_r, cms_r);
    cq2 = fmul(cq_r, omp_r);
    fp = fsub(p3_r, phi2_r);
  end
  fx_t c4t_r, s4m_r, cq2_r, fp_r, eu3_r, gx3_r, gy3_r;
  logic f3_r;
  always_ff @(posedge clk) if (en) begin
    c4t_r <= c4t.v; s4m_r <= s4m.v; cq2_r <= cq2.v; fp_r <= fp.v;
    eu3_r <= eu2_r; gx3_r <= gx2_r; gy3_r <= gy2_r;
    f3_r <= f2_r | a1.f | six.f | c4t.f | s4m.f | cq2.f | fp.f;
  end

  sres_t s4t, ec, dfm;
  always_comb begin
    s4t = sat66(66'(s4m_r) * 66'sd4);
    ec = fmul(fx_t'({7'd0, cfg_r.aniso_strength}), c4t_r);
    dfm = fmul(cq2_r, eu3_r);
  end
  fx_t s4t_r, ec_r, df_r, fp4_r, gx4_r, gy4_r;
  logic f4_r;
  always_ff @(posedge clk) if (en) begin
    s4t_r <= s4t.v; ec_r <= ec.v; df_r <= dfm.v; fp4_r <= fp_r;
    gx4_r <= gx3_r; gy4_r <= gy3_r;
    f4_r <= f3_r | s4t.f | ec.f | dfm.f;
  end

  sres_t an, es, dfn, val;
  always_comb begin
    an = fadd(one, ec_r);
    es = fmul(fx_t'({7'd0, cfg_r.aniso_strength}), s4t_r);
    dfn = sat66(-66'(df_r));
    val = fsub(dfn.v, fp4_r);
  end
  fx_t an_r, es_r, val5_r, gx5_r, gy5_r;
  logic f5_r;
  always_ff @(posedge clk) if (en) begin
    an_r <= an.v; es_r <= es.v; val5_r <= val.v; gx5_r <= gx4_r; gy5_r <= gy4_r;
    f5_r <= f4_r | an.f | es.f | dfn.f | val.f;
  end

  sres_t ad;
  always_comb ad = sat66(66'(es_r) * -66'sd4);
  fx_t an6_r, ad6_r, val6_r, gx6_r, gy6_r;
  logic f6_r;
  always_ff @(posedge clk) if (en) begin
    an6_r <= an_r; ad6_r <= ad.v; val6_r <= val5_r; gx6_r <= gx5_r; gy6_r <= gy5_r;
    f6_r <= f5_r | ad.f;
  end

  sres_t ann, anad;
  always_comb begin
    ann = fmul(an6_r, an6_r); anad = fmul(an6_r, ad6_r);
  end
  fx_t ann_r, anad_r, val7_r, gx7_r, gy7_r;
  logic f7_r;
  always_ff @(posedge clk) if (en) begin
    ann_r <= ann.v; anad_r <= anad.v; val7_r <= val6_r; gx7_r <= gx6_r; gy7_r <= gy6_r;
    f7_r <= f6_r | ann.f | anad.f;
  end

  sres_t m1, m2, m3, m4;
  always_comb begin
    m1 = fmul(ann_r, gx7_r); m2 = fmul(anad_r, gy7_r);
    m3 = fmul(ann_r, gy7_r); m4 = fmul(anad_r, gx7_r);
  end
  fx_t m1_r, m2_r, m3_r, m4_r, val8_r;
  logic f8_r;
  always_ff @(posedge clk) if (en) begin
    m1_r <= m1.v; m2_r <= m2.v; m3_r <= m3.v; m4_r <= m4.v; val8_r <= val7_r;
    f8_r <= f7_r | m1.f | m2.f | m3.f | m4.f;
  end

  sres_t tx, ty;
  always_comb begin
    tx = fsub(m1_r, m2_r); ty = fadd(m3_r, m4_r);
  end
  fx_t tx_r, ty_r, val9_r;
  logic f9_r;
  always_ff @(posedge clk) if (en) begin
    tx_r <= tx.v; ty_r <= ty.v; val9_r <= val8_r; f9_r <= f8_r | tx.f | ty.f;
  end

  sres_t wx, wy;
  always_comb begin
    wx = fmul(fx_t'({1'b0, cfg_r.width_squared}), tx_r);
    wy = fmul(fx_t'({1'b0, cfg_r.width_squared}), ty_r);
  end
  fx_t wx_r, wy_r, val10_r;
  logic f10_r;
  always_ff @(posedge clk) if (en) begin
    wx_r <= wx.v; wy_r <= wy.v; val10_r <= val9_r; f10_r <= f9_r | wx.f | wy.f;
  end

  sres_t nx, ny;
  always_comb begin
    nx = sat66(-66'(wx_r)); ny = sat66(-66'(wy_r));
  end
  fx_t ox_r, oy_r, ov_r;
  logic of_r;
  always_ff @(posedge clk) if (en) begin
    ox_r <= nx.v; oy_r <= ny.v; ov_r <= val10_r; of_r <= f10_r | nx.f | ny.f;
  end

  // remaining valid slots are spare delay to match LAT
  localparam int TAIL = LAT - 32 - QB - 11;
  fx_t tv_r [0:TAIL], tx_d [0:TAIL], ty_d [0:TAIL];
  logic tf_r [0:TAIL];
  always_comb begin
    tv_r[0] = ov_r; tx_d[0] = ox_r; ty_d[0] = oy_r; tf_r[0] = of_r;
  end
  for (genvar i = 0; i < TAIL; i++) begin : g_t
    always_ff @(posedge clk) if (en) begin
      tv_r[i+1] <= tv_r[i]; tx_d[i+1] <= tx_d[i]; ty_d[i+1] <= ty_d[i];
      tf_r[i+1] <= tf_r[i];
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata = {ty_d[TAIL], tx_d[TAIL], tv_r[TAIL]};
  assign out_tuser = tf_r[TAIL];

  `PF_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)
  `PF_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `PF_ASSERT_NEXT(a_stall_freezes_pipe, clk, rst_n, !in_tready, $stable(vld_r))
endmodule
